[rtl/decaying_counter_ram_node_core_macros.svh]
// Assertion macros used by the decaying counter RAM node controller.
`ifndef DECAYING_COUNTER_RAM_NODE_CORE_MACROS_SVH
`define DECAYING_COUNTER_RAM_NODE_CORE_MACROS_SVH
`ifndef SYNTH
`define DCRN_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("dcrn assertion failed");
`define DCRN_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("dcrn assertion failed");
`else
`define DCRN_ASSERT(lbl, clk, rstn, prop)
`define DCRN_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[rtl/dcrn_pkg.sv]
// Types and constants shared by the decaying counter RAM node modules.
`default_nettype none
package dcrn_pkg;

    localparam int ADDR_W      = 10;
    localparam int AMOUNT_W    = 8;
    localparam int READ_W      = 16;
    localparam int ABITS_W     = 4;
    localparam int MAXV_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 24;
    localparam int S_TUSER_W   = 2;
    localparam int M_TDATA_W   = 16;

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_SET   = 2'd1,
        MODE_READ  = 2'd2,
        MODE_DECAY = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ADDR_BITS   = 2'd0,
        CFG_MAX_VALUE   = 2'd1,
        CFG_IGNORE_ZERO = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic accept;
        logic sweep_start;
        logic sweep_clear;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic sweep_busy;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

[rtl/decaying_counter_ram_node_core.sv]
// Top level of the decaying counter RAM node: stream ports, controller and datapath.
// Each input beat runs one operation on a memory of 2^ADDR_BITS saturating counters. Add, set
// and read are accepted in ST_IDLE, where the counter is read through the memory's registered
// read port; ST_FINISH then writes add and set results back and loads the result register; a
// result beat that has not been taken yet holds the operation in ST_FINISH until m_axis_tready
// frees the register. Decay sweeps the memory with one read and one write per cycle before the
// next beat can be accepted. After reset a clearing pass zeroes the memory and s_axis_tready
// stays low until it is done; configuration writes are taken at any time and must only be
// issued while no beat is in flight.
`default_nettype none
module decaying_counter_ram_node_core #(
    parameter int ADDR_BITS  = 10,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // s_axis_tdata: address[9:0], amount[17:10], zero pad[23:18]
    input  wire logic [dcrn_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // s_axis_tuser: mode[1:0]
    input  wire logic [dcrn_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // m_axis_tdata: read_value[15:0]
    output logic [dcrn_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    // m_axis_tuser: bad_address[0]
    output logic [0:0]                           m_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [dcrn_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dcrn_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dcrn_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    t_mode mode;
    logic  bad;

    assign mode        = t_mode'(s_axis_tuser);
    assign o_cfg_ready = 1'b1;

    dcrn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_mode     (mode),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    dcrn_dp #(
        .ADDR_BITS  (ADDR_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_mode        (mode),
        .i_address     (s_axis_tdata[ADDR_W-1:0]),
        .i_amount      (s_axis_tdata[ADDR_W+AMOUNT_W-1:ADDR_W]),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_read_value  (m_axis_tdata),
        .o_bad_address (bad)
    );

    assign m_axis_tuser[0] = bad;

endmodule
`default_nettype wire

[rtl/dcrn_dp.sv]
// Datapath of the decaying counter RAM node: counter memory, sweep engine and result register.
`default_nettype none
module dcrn_dp #(
    parameter int ADDR_BITS  = 10,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire dcrn_pkg::t_cmd                  i_cmd,
    output dcrn_pkg::t_stat                      o_stat,
    input  wire dcrn_pkg::t_mode                 i_mode,
    input  wire logic [dcrn_pkg::ADDR_W-1:0]     i_address,
    input  wire logic [dcrn_pkg::AMOUNT_W-1:0]   i_amount,
    input  wire logic                            i_cfg_we,
    input  wire logic [dcrn_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [dcrn_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [dcrn_pkg::READ_W-1:0]          o_read_value,
    output logic                                 o_bad_address
);
    import dcrn_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;
    localparam int AXW   = (ADDR_BITS > ADDR_W) ? ADDR_BITS : ADDR_W;
    localparam int CXW   = (COUNT_BITS > READ_W) ? COUNT_BITS : READ_W;
    localparam int SW    = ((COUNT_BITS > AMOUNT_W) ? COUNT_BITS : AMOUNT_W) + 1;
    localparam logic [COUNT_BITS-1:0] CTOP = '1;
    localparam logic [ADDR_BITS-1:0]  LAST = ADDR_BITS'(DEPTH - 1);

    logic [COUNT_BITS-1:0] r_mem [DEPTH];
    logic [COUNT_BITS-1:0] r_rdata;

    logic [ABITS_W-1:0]    r_cfg_abits;
    logic [MAXV_W-1:0]     r_cfg_max;
    logic                  r_cfg_ign;

    t_mode                 r_mode;
    logic [ADDR_W-1:0]     r_addr;
    logic [ADDR_BITS-1:0]  r_idx;
    logic [AMOUNT_W-1:0]   r_amount;
    logic                  r_bad;

    logic                  r_sw_act;
    logic                  r_sw_clear;
    logic [ADDR_BITS-1:0]  r_sw_idx;
    logic                  r_wpend;
    logic [ADDR_BITS-1:0]  r_widx;

    logic                  r_out_valid;
    logic [READ_W-1:0]     r_out_data;
    logic                  r_out_bad;

    logic [AXW-1:0]        addr_ext;
    logic [ADDR_BITS-1:0]  in_idx;
    logic                  in_bad;
    logic                  re;
    logic [ADDR_BITS-1:0]  raddr;
    logic                  we;
    logic [ADDR_BITS-1:0]  waddr;
    logic [COUNT_BITS-1:0] wdata;
    logic [COUNT_BITS-1:0] dec_val;
    logic [SW-1:0]         sum;
    logic [COUNT_BITS-1:0] add_val;
    logic [COUNT_BITS-1:0] set_val;
    logic [CXW-1:0]        rd_ext;
    logic [READ_W-1:0]     rd_sat;
    logic [READ_W-1:0]     result;
    logic                  rmw_write;

    always_comb begin
        addr_ext = AXW'(i_address);
        in_idx   = addr_ext[ADDR_BITS-1:0];
        if (int'(r_cfg_abits) > ADDR_BITS) begin
            in_bad = (i_address >> ADDR_BITS) != '0;
        end else begin
            in_bad = (i_address >> r_cfg_abits) != '0;
        end
    end

    always_comb begin
        dec_val = (r_rdata == '0) ? '0 : r_rdata - COUNT_BITS'(1);
        sum     = SW'(r_rdata) + SW'(r_amount);
        add_val = (sum > SW'(CTOP)) ? CTOP : sum[COUNT_BITS-1:0];
        set_val = (CXW'(r_cfg_max) > CXW'(CTOP)) ? CTOP : COUNT_BITS'(r_cfg_max);
        rd_ext  = CXW'(r_rdata);
        rd_sat  = (rd_ext > CXW'({READ_W{1'b1}})) ? '1 : rd_ext[READ_W-1:0];
        if (r_mode == MODE_READ && !r_bad && !(r_cfg_ign && r_addr == '0)) begin
            result = rd_sat;
        end else begin
            result = '0;
        end
        rmw_write = (r_mode == MODE_ADD || r_mode == MODE_SET) && !r_bad;
    end

    always_comb begin
        re    = i_cmd.accept || r_sw_act;
        raddr = i_cmd.accept ? in_idx : r_sw_idx;
        we    = r_wpend || (i_cmd.finish && rmw_write);
        if (r_wpend) begin
            waddr = r_widx;
            wdata = r_sw_clear ? '0 : dec_val;
        end else begin
            waddr = r_idx;
            wdata = (r_mode == MODE_SET) ? set_val : add_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        if (re) begin
            r_rdata <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode   <= i_mode;
            r_addr   <= i_address;
            r_idx    <= in_idx;
            r_amount <= i_amount;
            r_bad    <= in_bad && (i_mode != MODE_DECAY);
        end
        r_widx <= r_sw_idx;
        if (i_cmd.finish) begin
            r_out_data <= result;
            r_out_bad  <= r_bad;
        end
        if (i_cmd.sweep_start) begin
            r_sw_clear <= i_cmd.sweep_clear;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_abits <= ABITS_W'(10);
            r_cfg_max   <= '1;
            r_cfg_ign   <= 1'b0;
            r_sw_act    <= 1'b0;
            r_sw_idx    <= '0;
            r_wpend     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ADDR_BITS:   r_cfg_abits <= i_cfg_data[ABITS_W-1:0];
                    CFG_MAX_VALUE:   r_cfg_max   <= i_cfg_data[MAXV_W-1:0];
                    CFG_IGNORE_ZERO: r_cfg_ign   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            r_wpend <= r_sw_act;
            if (i_cmd.sweep_start) begin
                r_sw_act <= 1'b1;
                r_sw_idx <= '0;
            end else if (r_sw_act) begin
                r_sw_idx <= r_sw_idx + ADDR_BITS'(1);
                if (r_sw_idx == LAST) begin
                    r_sw_act <= 1'b0;
                end
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.sweep_busy = r_sw_act || r_wpend;
    assign o_stat.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_read_value      = r_out_data;
    assign o_bad_address     = r_out_bad;

endmodule
`default_nettype wire

[rtl/dcrn_ctrl.sv]
// Controller state machine of the decaying counter RAM node.
`default_nettype none
`include "decaying_counter_ram_node_core_macros.svh"
module dcrn_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire dcrn_pkg::t_mode i_mode,
    input  wire dcrn_pkg::t_stat i_stat,
    output dcrn_pkg::t_cmd       o_cmd
);
    import dcrn_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.sweep_start = 1'b1;
                o_cmd.sweep_clear = 1'b1;
                n_state           = ST_CLEAR;
            end
            ST_CLEAR: begin
                if (!i_stat.sweep_busy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_mode == MODE_DECAY) begin
                        o_cmd.sweep_start = 1'b1;
                        n_state           = ST_SWEEP;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_SWEEP: begin
                if (!i_stat.sweep_busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

    `DCRN_ASSERT(a_idle_no_sweep, i_clk, i_rst_n, (r_state == ST_IDLE) |-> !i_stat.sweep_busy)
    `DCRN_ASSERT(a_accept_moves, i_clk, i_rst_n, (r_state == ST_IDLE && i_in_valid) |=> (r_state == ST_FINISH || r_state == ST_SWEEP))
    `DCRN_ASSERT(a_finish_free, i_clk, i_rst_n, o_cmd.finish |-> i_stat.out_free)
    `DCRN_ASSERT_ALWAYS(a_reset_init, i_clk, !i_rst_n |=> (r_state == ST_INIT))

endmodule
`default_nettype wire

[tb/tb_decaying_counter_ram_node_core.sv]
// Self-checking testbench of the decaying counter RAM node: directed and random beats checked against a predictor.
`default_nettype none
module tb_decaying_counter_ram_node_core;
    import dcrn_pkg::*;

    localparam int NODE_DEPTH     = 1 << ADDR_W;
    localparam int COUNT_TOP      = (1 << READ_W) - 1;
    localparam int RX_HOLD_CYCLES = 300;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [READ_W-1:0] read_value;
        logic              bad_address;
    } t_node_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [S_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    logic [READ_W-1:0]  counter_mem [NODE_DEPTH];
    logic [ABITS_W-1:0] cfg_addr_bits = 4'd10;
    logic [MAXV_W-1:0]  cfg_max_value = 16'hFFFF;
    logic               cfg_ignore_zero = 1'b0;

    t_node_result pending_results [$];
    t_node_result expected_result;
    int           fail_count = 0;
    int           tx_idle_pct = 0;
    int           rx_stall_pct = 0;
    int           hold_req = 0;
    int           hold_seen = 0;
    int           hold_left = 0;

    decaying_counter_ram_node_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < NODE_DEPTH; i++) begin
            counter_mem[i] = '0;
        end
    end

    function automatic t_node_result node_step(input t_mode mode, input logic [ADDR_W-1:0] addr,
                                               input logic [AMOUNT_W-1:0] amount);
        t_node_result res;
        int           eff_bits;
        int           sum;
        res = '0;
        eff_bits = (cfg_addr_bits > ADDR_W) ? ADDR_W : int'(cfg_addr_bits);
        if (mode == MODE_DECAY) begin
            for (int i = 0; i < NODE_DEPTH; i++) begin
                if (counter_mem[i] != 0) begin
                    counter_mem[i] = counter_mem[i] - 1'b1;
                end
            end
        end else if (int'(addr) >= (1 << eff_bits)) begin
            res.bad_address = 1'b1;
        end else begin
            case (mode)
                MODE_ADD: begin
                    sum = int'(counter_mem[addr]) + int'(amount);
                    counter_mem[addr] = (sum > COUNT_TOP) ? READ_W'(COUNT_TOP) : READ_W'(sum);
                end
                MODE_SET: begin
                    counter_mem[addr] = cfg_max_value;
                end
                default: begin
                    if (!(cfg_ignore_zero && addr == 0)) begin
                        res.read_value = counter_mem[addr];
                    end
                end
            endcase
        end
        return res;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("mismatch: %s", msg);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                note_failure($sformatf("unexpected beat read_value %0d bad_address %0d",
                                       m_axis_tdata, m_axis_tuser[0]));
            end else begin
                expected_result = pending_results.pop_front();
                if (m_axis_tdata !== expected_result.read_value) begin
                    note_failure($sformatf("read_value expected %0d got %0d",
                                           expected_result.read_value, m_axis_tdata));
                end
                if (m_axis_tuser[0] !== expected_result.bad_address) begin
                    note_failure($sformatf("bad_address expected %0d got %0d",
                                           expected_result.bad_address, m_axis_tuser[0]));
                end
            end
        end
    end

    // The receiver holds off for a long stretch whenever a hold is requested.
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= RX_HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_item(input t_mode mode, input logic [ADDR_W-1:0] addr,
                             input logic [AMOUNT_W-1:0] amount);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(S_TDATA_W - ADDR_W - AMOUNT_W){1'b0}}, amount, addr};
        s_axis_tuser <= mode;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        pending_results.push_back(node_step(mode, addr, amount));
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        drain_results();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_ADDR_BITS:   cfg_addr_bits = data[ABITS_W-1:0];
            CFG_MAX_VALUE:   cfg_max_value = data[MAXV_W-1:0];
            CFG_IGNORE_ZERO: cfg_ignore_zero = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random_item();
        int                  lim;
        int                  pick;
        t_mode               mode;
        logic [ADDR_W-1:0]   addr;
        logic [AMOUNT_W-1:0] amount;
        lim = 1 << ((cfg_addr_bits > ADDR_W) ? ADDR_W : int'(cfg_addr_bits));
        pick = $urandom_range(99);
        mode = (pick < 5) ? MODE_DECAY : (pick < 40) ? MODE_ADD : (pick < 50) ? MODE_SET : MODE_READ;
        pick = $urandom_range(99);
        if (pick < 10) begin
            addr = ADDR_W'($urandom);
        end else if (pick < 60) begin
            addr = ADDR_W'($urandom_range(((lim < 8) ? lim : 8) - 1));
        end else begin
            addr = ADDR_W'($urandom_range(lim - 1));
        end
        pick = $urandom_range(99);
        amount = (pick < 20) ? 8'hFF : (pick < 30) ? 8'h00 : AMOUNT_W'($urandom);
        send_item(mode, addr, amount);
    endtask

    task automatic test_after_reset();
        send_item(MODE_READ, 10'd0, 8'd0);
        send_item(MODE_READ, 10'd1023, 8'hFF);
        send_item(MODE_READ, 10'd517, 8'h5A);
    endtask

    task automatic test_operations();
        send_item(MODE_ADD, 10'd5, 8'hFF);
        send_item(MODE_ADD, 10'd5, 8'h00);
        send_item(MODE_READ, 10'd5, 8'd0);
        send_item(MODE_SET, 10'd6, 8'd0);
        send_item(MODE_ADD, 10'd6, 8'hFF);
        send_item(MODE_READ, 10'd6, 8'd0);
        send_item(MODE_ADD, 10'd1023, 8'd1);
        send_item(MODE_DECAY, 10'd0, 8'd0);
        send_item(MODE_DECAY, 10'd1023, 8'hFF);
        send_item(MODE_READ, 10'd5, 8'd0);
        send_item(MODE_READ, 10'd6, 8'd0);
        send_item(MODE_READ, 10'd1023, 8'd0);
    endtask

    task automatic test_address_range();
        // Only the low four data bits reach the register.
        cfg_write(CFG_ADDR_BITS, 16'hFFF0);
        send_item(MODE_ADD, 10'd1, 8'd10);
        send_item(MODE_SET, 10'd1, 8'd0);
        send_item(MODE_READ, 10'd1, 8'd0);
        send_item(MODE_ADD, 10'd0, 8'd3);
        send_item(MODE_READ, 10'd0, 8'd0);
        cfg_write(CFG_ADDR_BITS, 16'h000F);
        send_item(MODE_READ, 10'd1023, 8'd0);
        cfg_write(CFG_ADDR_BITS, 16'h0001);
        send_item(MODE_READ, 10'd2, 8'd0);
        send_item(MODE_DECAY, 10'd1023, 8'd0);
    endtask

    task automatic test_zero_address();
        cfg_write(CFG_IGNORE_ZERO, 16'hFFFF);
        send_item(MODE_READ, 10'd0, 8'd0);
        cfg_write(CFG_IGNORE_ZERO, 16'hFFFE);
        send_item(MODE_READ, 10'd0, 8'd0);
    endtask

    task automatic test_max_value();
        cfg_write(CFG_ADDR_BITS, 16'd10);
        cfg_write(CFG_MAX_VALUE, 16'h0000);
        send_item(MODE_SET, 10'd5, 8'd0);
        send_item(MODE_READ, 10'd5, 8'd0);
        cfg_write(CFG_MAX_VALUE, 16'hA5A5);
        cfg_write(CFG_UNUSED, 16'h5A5A);
        send_item(MODE_SET, 10'd512, 8'd0);
        send_item(MODE_READ, 10'd512, 8'd0);
    endtask

    task automatic test_backpressure();
        drain_results();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_req++;
        for (int i = 0; i < 16; i++) begin
            send_random_item();
        end
        drain_results();
    endtask

    task automatic test_random_traffic(input int count, input int tx_pct, input int rx_pct,
                                       input logic [15:0] abits, input logic [15:0] maxv,
                                       input logic [15:0] ign);
        cfg_write(CFG_ADDR_BITS, abits);
        cfg_write(CFG_MAX_VALUE, maxv);
        cfg_write(CFG_IGNORE_ZERO, ign);
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        for (int i = 0; i < count; i++) begin
            send_random_item();
        end
        drain_results();
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_after_reset();
        test_operations();
        test_address_range();
        test_zero_address();
        test_max_value();
        test_backpressure();
        test_random_traffic(275, 0, 0, 16'd10, 16'hFFFF, 16'd0);
        test_random_traffic(275, 76, 0, 16'd3, 16'd1000, 16'd1);
        test_random_traffic(275, 0, 76, 16'd12, 16'd0, 16'd0);
        test_random_traffic(275, 15, 15, 16'd1, 16'hFFFF, 16'd1);
        drain_results();
        repeat (NODE_DEPTH + 16) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #(64'd8 * 64'd6000000);
        $display("TB_ERROR");
        $finish;
    end

endmodule
`default_nettype wire

[sim.f]
+incdir+rtl
rtl/dcrn_pkg.sv
rtl/dcrn_dp.sv
rtl/dcrn_ctrl.sv
rtl/decaying_counter_ram_node_core.sv
tb/tb_decaying_counter_ram_node_core.sv
